[sv/d2d_pkg.sv]
// Package with shared types and twiddle tables for the direct 2-D DFT.
`default_nettype none
package d2d_pkg;
   typedef struct packed {
      logic signed [15:0] sample_real;
      logic signed [15:0] sample_imag;
   } req_payload_type;

   typedef struct packed {
      logic signed [23:0] freq_real;
      logic signed [23:0] freq_imag;
      logic [2:0]         row_index;
      logic [2:0]         col_index;
      logic               last_of_frame;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_LOAD, ST_READ, ST_MAC, ST_SUM, ST_WRITE, ST_OUT_RD, ST_OUT
   } state_type;

   localparam int unsigned CSR_ROWS = 0;
   localparam int unsigned CSR_COLS = 1;

   function automatic logic signed [15:0] tw_cos(input logic [3:0] len, input logic [2:0] t);
      logic signed [15:0] v;
      v = 16'sd0;
      case (len)
         4'd1: v = (t == 3'd0) ? 16'sd32767 : 16'sd0;
         4'd2: case (t) 3'd0: v = 16'sd32767; 3'd1: v = -16'sd32768; default: v = 16'sd0; endcase
         4'd3: case (t) 3'd0: v = 16'sd32767; 3'd1, 3'd2: v = -16'sd16384;
                        default: v = 16'sd0; endcase
         4'd4: case (t) 3'd0: v = 16'sd32767; 3'd2: v = -16'sd32768; default: v = 16'sd0; endcase
         4'd5: case (t) 3'd0: v = 16'sd32767; 3'd1, 3'd4: v = 16'sd10126;
                        3'd2, 3'd3: v = -16'sd26510; default: v = 16'sd0; endcase
         4'd6: case (t) 3'd0: v = 16'sd32767; 3'd1, 3'd5: v = 16'sd16384;
                        3'd2, 3'd4: v = -16'sd16384; 3'd3: v = -16'sd32768;
                        default: v = 16'sd0; endcase
         4'd7: case (t) 3'd0: v = 16'sd32767; 3'd1, 3'd6: v = 16'sd20431;
                        3'd2, 3'd5: v = -16'sd7292; 3'd3, 3'd4: v = -16'sd29523;
                        default: v = 16'sd0; endcase
         4'd8: case (t) 3'd0: v = 16'sd32767; 3'd1, 3'd7: v = 16'sd23170;
                        3'd3, 3'd5: v = -16'sd23170; 3'd4: v = -16'sd32768;
                        default: v = 16'sd0; endcase
         default: v = 16'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [15:0] tw_sin(input logic [3:0] len, input logic [2:0] t);
      logic signed [15:0] v;
      v = 16'sd0;
      case (len)
         4'd3: case (t) 3'd1: v = 16'sd28378; 3'd2: v = -16'sd28378; default: v = 16'sd0; endcase
         4'd4: case (t) 3'd1: v = 16'sd32767; 3'd3: v = -16'sd32768; default: v = 16'sd0; endcase
         4'd5: case (t) 3'd1: v = 16'sd31164; 3'd2: v = 16'sd19261; 3'd3: v = -16'sd19261;
                        3'd4: v = -16'sd31164; default: v = 16'sd0; endcase
         4'd6: case (t) 3'd1, 3'd2: v = 16'sd28378; 3'd4, 3'd5: v = -16'sd28378;
                        default: v = 16'sd0; endcase
         4'd7: case (t) 3'd1: v = 16'sd25619; 3'd2: v = 16'sd31946; 3'd3: v = 16'sd14218;
                        3'd4: v = -16'sd14218; 3'd5: v = -16'sd31946; 3'd6: v = -16'sd25619;
                        default: v = 16'sd0; endcase
         4'd8: case (t) 3'd1, 3'd3: v = 16'sd23170; 3'd2: v = 16'sd32767;
                        3'd5, 3'd7: v = -16'sd23170; 3'd6: v = -16'sd32768;
                        default: v = 16'sd0; endcase
         default: v = 16'sd0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

[sv/d2d_mac.sv]
// Shared complex multiply-accumulate unit with rounding and saturation.
`default_nettype none
module d2d_mac
   import d2d_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               clear,
   input  wire logic               enable,
   input  wire logic signed [23:0] x_real,
   input  wire logic signed [23:0] x_imag,
   input  wire logic signed [15:0] c_val,
   input  wire logic signed [15:0] s_val,
   output logic signed [23:0]      sum_real,
   output logic signed [23:0]      sum_imag
);
   // Products are registered, then accumulated in the following cycle.
   logic signed [39:0] p_rc_ff, p_is_ff, p_ic_ff, p_rs_ff;
   logic               p_valid_ff;
   logic signed [45:0] acc_real_ff, acc_imag_ff;
   logic signed [45:0] acc_real_in, acc_imag_in;

   always_ff @(posedge clock) begin
      p_rc_ff    <= x_real * c_val;
      p_is_ff    <= x_imag * s_val;
      p_ic_ff    <= x_imag * c_val;
      p_rs_ff    <= x_real * s_val;
      p_valid_ff <= enable;
      acc_real_ff <= acc_real_in;
      acc_imag_ff <= acc_imag_in;
   end

   always_comb begin
      acc_real_in = acc_real_ff;
      acc_imag_in = acc_imag_ff;
      if (clear) begin
         acc_real_in = '0;
         acc_imag_in = '0;
      end else if (p_valid_ff) begin
         acc_real_in = acc_real_ff + 46'(p_rc_ff) + 46'(p_is_ff);
         acc_imag_in = acc_imag_ff + 46'(p_ic_ff) - 46'(p_rs_ff);
      end
   end

   function automatic logic signed [23:0] rsat(input logic signed [45:0] a);
      logic signed [45:0] v;
      logic signed [30:0] q;
      v = a + 46'sd16384;
      q = v[45:15];
      if (q > 31'sd8388607) return 24'sd8388607;
      if (q < -31'sd8388608) return -24'sd8388608;
      return q[23:0];
   endfunction

   assign sum_real = rsat(acc_real_ff);
   assign sum_imag = rsat(acc_imag_ff);
endmodule
`default_nettype wire

[sv/direct_2d_dft.sv]
// Top level of the direct 2-D DFT: frame store, sequencer and output stage.
// Sequence: after the last sample, each coefficient of a line of length len is formed by reading
// and multiply-accumulating the line's elements, then draining the accumulator; each line is then
// written back from the line buffer. The row pass is followed by the column pass, and the results
// are then read out in row order, each read issued in ST_OUT_RD and presented in ST_OUT.
// busy is high from the last sample until the final result; the receiver cannot stall.
// Synchronous active-high reset clears the sequencer and load count, and sets sizes to 8.
`default_nettype none
module direct_2d_dft
   import d2d_pkg::*;
#(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLS = 8
)(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_write,
   input  wire logic            csr_index,
   input  wire logic [3:0]      csr_data
);
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);

   logic [3:0] rows_reg_ff, cols_reg_ff;
   logic [3:0] rows_eff, cols_eff;
   logic [6:0] load_count_ff, load_count_in;

   // The frame memory holds samples, then the row and column results.
   logic signed [23:0] mem_real [DEPTH];
   logic signed [23:0] mem_imag [DEPTH];
   logic signed [23:0] rd_real_ff, rd_imag_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic signed [23:0] wr_real, wr_imag;
   logic          wr_en;

   // The line buffer holds one row or column of pass results.
   logic signed [23:0] line_real_ff [8];
   logic signed [23:0] line_imag_ff [8];

   state_type state_ff, state_in;
   logic       col_pass_ff, col_pass_in;
   logic [2:0] line_ff, line_in, k_ff, k_in, n_ff, n_in;
   logic [2:0] t_ff, t_in;
   logic [3:0] t_sum;
   logic [1:0] wait_ff, wait_in;
   logic [2:0] orow_ff, orow_in, ocol_ff, ocol_in;
   logic       mac_clear, mac_en, line_wr;
   logic signed [23:0] sum_real, sum_imag;
   logic [3:0] len, nlines;

   function automatic logic [3:0] eff(input logic [3:0] raw, input int mx);
      if (raw == 4'd0) return 4'd1;
      if (int'(raw) > mx) return 4'(mx);
      return raw;
   endfunction

   assign rows_eff = eff(rows_reg_ff, MAX_ROWS);
   assign cols_eff = eff(cols_reg_ff, MAX_COLS);
   assign len      = col_pass_ff ? rows_eff : cols_eff;
   assign nlines   = col_pass_ff ? cols_eff : rows_eff;

   // The twiddle index k*n mod len advances by k per element and wraps once at most.
   assign t_sum    = 4'(t_ff) + 4'(k_ff);

   // Element address of position p on the current line.
   function automatic logic [AW-1:0] laddr(input logic cp, input logic [2:0] ln,
                                           input logic [2:0] p, input logic [3:0] cols);
      logic [6:0] a;
      a = cp ? (7'(p) * 7'(cols) + 7'(ln)) : (7'(ln) * 7'(cols) + 7'(p));
      return a[AW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_reg_ff <= 4'd8;
         cols_reg_ff <= 4'd8;
      end else if (csr_write) begin
         if (csr_index == 1'(CSR_ROWS)) rows_reg_ff <= csr_data;
         else cols_reg_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_real[wr_addr] <= wr_real;
         mem_imag[wr_addr] <= wr_imag;
      end
      rd_real_ff <= mem_real[rd_addr];
      rd_imag_ff <= mem_imag[rd_addr];
      if (line_wr) begin
         line_real_ff[k_ff] <= sum_real;
         line_imag_ff[k_ff] <= sum_imag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         load_count_ff <= '0;
      end else begin
         state_ff <= state_in;
         load_count_ff <= load_count_in;
      end
      col_pass_ff <= col_pass_in;
      line_ff <= line_in; k_ff <= k_in; n_ff <= n_in; t_ff <= t_in;
      wait_ff <= wait_in; orow_ff <= orow_in; ocol_ff <= ocol_in;
   end

   d2d_mac u_mac (
      .clock(clock), .clear(mac_clear), .enable(mac_en),
      .x_real(rd_real_ff), .x_imag(rd_imag_ff),
      .c_val(tw_cos(len, t_ff)), .s_val(tw_sin(len, t_ff)),
      .sum_real(sum_real), .sum_imag(sum_imag)
   );

   always_comb begin
      state_in = state_ff;
      load_count_in = load_count_ff;
      col_pass_in = col_pass_ff;
      line_in = line_ff; k_in = k_ff; n_in = n_ff; t_in = t_ff;
      wait_in = wait_ff; orow_in = orow_ff; ocol_in = ocol_ff;
      wr_en = 1'b0; wr_addr = '0; wr_real = '0; wr_imag = '0;
      rd_addr = '0; mac_clear = 1'b0; mac_en = 1'b0; line_wr = 1'b0;
      busy = 1'b1; rsp_valid = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            busy = 1'b0;
            if (start) begin
               wr_en = 1'b1;
               wr_addr = load_count_ff[AW-1:0];
               wr_real = 24'(req_payload.sample_real);
               wr_imag = 24'(req_payload.sample_imag);
               if (8'(load_count_ff) + 8'd1 < 8'(rows_eff) * 8'(cols_eff)) begin
                  load_count_in = load_count_ff + 7'd1;
               end else begin
                  load_count_in = '0;
                  state_in = ST_READ;
                  col_pass_in = 1'b0;
                  line_in = '0; k_in = '0; n_in = '0; t_in = '0;
               end
            end
         end
         ST_READ: begin
            // Issue the read of element n; clear the accumulator at the start of each coefficient.
            mac_clear = (n_ff == 3'd0);
            rd_addr = laddr(col_pass_ff, line_ff, n_ff, cols_eff);
            state_in = ST_MAC;
         end
         ST_MAC: begin
            mac_en = 1'b1;
            if (4'(n_ff) + 4'd1 < len) begin
               n_in = n_ff + 3'd1;
               t_in = (t_sum >= len) ? 3'(t_sum - len) : t_sum[2:0];
               state_in = ST_READ;
            end else begin
               n_in = '0;
               t_in = '0;
               wait_in = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // Wait for the last product to pass the product register and reach the accumulator.
            wait_in = wait_ff + 2'd1;
            if (wait_ff == 2'd1) begin
               line_wr = 1'b1;
               if (4'(k_ff) + 4'd1 < len) begin
                  k_in = k_ff + 3'd1;
                  state_in = ST_READ;
               end else begin
                  k_in = '0;
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            wr_en = 1'b1;
            wr_addr = laddr(col_pass_ff, line_ff, k_ff, cols_eff);
            wr_real = line_real_ff[k_ff];
            wr_imag = line_imag_ff[k_ff];
            if (4'(k_ff) + 4'd1 < len) begin
               k_in = k_ff + 3'd1;
            end else begin
               k_in = '0;
               if (4'(line_ff) + 4'd1 < nlines) begin
                  line_in = line_ff + 3'd1;
                  state_in = ST_READ;
               end else if (!col_pass_ff) begin
                  line_in = '0;
                  col_pass_in = 1'b1;
                  state_in = ST_READ;
               end else begin
                  orow_in = '0; ocol_in = '0;
                  state_in = ST_OUT_RD;
               end
            end
         end
         ST_OUT_RD: begin
            rd_addr = laddr(1'b0, orow_ff, ocol_ff, cols_eff);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (4'(ocol_ff) + 4'd1 < cols_eff) begin
               ocol_in = ocol_ff + 3'd1;
               state_in = ST_OUT_RD;
            end else begin
               ocol_in = '0;
               if (4'(orow_ff) + 4'd1 < rows_eff) begin
                  orow_in = orow_ff + 3'd1;
                  state_in = ST_OUT_RD;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      rsp_payload.freq_real = rd_real_ff;
      rsp_payload.freq_imag = rd_imag_ff;
      rsp_payload.row_index = orow_ff;
      rsp_payload.col_index = ocol_ff;
      rsp_payload.last_of_frame = (4'(orow_ff) + 4'd1 == rows_eff) &&
                                  (4'(ocol_ff) + 4'd1 == cols_eff);
   end
endmodule
`default_nettype wire
